[rtl/pick_and_place_colour_sequencer_defines.svh]
// ---------------------------------------------------------------------------
// Pick and place colour sequencer: assertion macros
// Shared assertion forms for the sequencer's port checker.
// ---------------------------------------------------------------------------
`ifndef PICK_AND_PLACE_COLOUR_SEQUENCER_DEFINES_SVH
`define PICK_AND_PLACE_COLOUR_SEQUENCER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PNP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next cycle
`define PNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pnp_pkg.sv]
// ---------------------------------------------------------------------------
// Pick and place colour sequencer package
// Request and response structs and the field codes of the sequencer.
// ---------------------------------------------------------------------------
package pnp_pkg;

    localparam int CHAN_W = 16;

    localparam logic [CHAN_W-1:0] MIN_LEVEL_RESET = 16'd1000;

    // phase codes
    localparam logic [2:0] PHASE_WAIT      = 3'd0;
    localparam logic [2:0] PHASE_LOOKING   = 3'd1;
    localparam logic [2:0] PHASE_GRABBING  = 3'd2;
    localparam logic [2:0] PHASE_GRABBED   = 3'd3;
    localparam logic [2:0] PHASE_LIFTING   = 3'd4;
    localparam logic [2:0] PHASE_RELEASING = 3'd5;
    localparam logic [2:0] PHASE_RESETTING = 3'd6;

    // actuator command codes
    localparam logic [1:0] JAWS_NONE  = 2'd0;
    localparam logic [1:0] JAWS_CLOSE = 2'd1;
    localparam logic [1:0] JAWS_OPEN  = 2'd2;

    localparam logic [1:0] LIFT_NONE = 2'd0;
    localparam logic [1:0] LIFT_UP   = 2'd1;
    localparam logic [1:0] LIFT_DOWN = 2'd2;

    localparam logic [1:0] PIVOT_NONE       = 2'd0;
    localparam logic [1:0] PIVOT_CENTRE     = 2'd1;
    localparam logic [1:0] PIVOT_RED_SIDE   = 2'd2;
    localparam logic [1:0] PIVOT_GREEN_SIDE = 2'd3;

    // colour class codes
    localparam logic [2:0] CLASS_OTHER   = 3'd0;
    localparam logic [2:0] CLASS_RED     = 3'd1;
    localparam logic [2:0] CLASS_GREEN   = 3'd2;
    localparam logic [2:0] CLASS_BLUE    = 3'd3;
    localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

    typedef struct packed {
        logic              run_request;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              jaws_closed;
        logic              jaws_open;
        logic              lifter_up;
        logic              lifter_down;
        logic              pivot_stopped;
    } pnp_req_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] jaws_action;
        logic [1:0] lifter_action;
        logic [1:0] pivot_target;
        logic       jaws_step;
        logic       lifter_step;
        logic       pivot_step;
        logic [2:0] colour_class;
    } pnp_rsp_t;

endpackage

[rtl/pnp_classify.sv]
// ---------------------------------------------------------------------------
// Colour classifier
// Sorts one RGB sample into unknown, red, green, blue or other. A colour
// wins when it exceeds 1.5 times each other channel, tested as 2x > 3y.
// ---------------------------------------------------------------------------
module pnp_classify
    import pnp_pkg::*;
(
    input  logic [CHAN_W-1:0] min_level,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output logic [2:0]        colour_class
);

    logic [CHAN_W+1:0] red_x2;
    logic [CHAN_W+1:0] green_x2;
    logic [CHAN_W+1:0] blue_x2;
    logic [CHAN_W+1:0] red_x3;
    logic [CHAN_W+1:0] green_x3;
    logic [CHAN_W+1:0] blue_x3;
    logic              below_min;
    logic              red_wins;
    logic              green_wins;
    logic              blue_wins;

    // scaled channels, two bits of headroom
    assign red_x2   = {1'b0, red, 1'b0};
    assign green_x2 = {1'b0, green, 1'b0};
    assign blue_x2  = {1'b0, blue, 1'b0};
    assign red_x3   = red_x2 + {2'b00, red};
    assign green_x3 = green_x2 + {2'b00, green};
    assign blue_x3  = blue_x2 + {2'b00, blue};

    // dominance tests
    assign below_min  = (red < min_level) || (green < min_level) || (blue < min_level);
    assign red_wins   = (red_x2 > green_x3) && (red_x2 > blue_x3);
    assign green_wins = (green_x2 > red_x3) && (green_x2 > blue_x3);
    assign blue_wins  = (blue_x2 > red_x3) && (blue_x2 > green_x3);

    // priority: unknown, red, green, blue
    always_comb
    begin
        if (below_min)
        begin
            colour_class = CLASS_UNKNOWN;
        end
        else if (red_wins)
        begin
            colour_class = CLASS_RED;
        end
        else if (green_wins)
        begin
            colour_class = CLASS_GREEN;
        end
        else if (blue_wins)
        begin
            colour_class = CLASS_BLUE;
        end
        else
        begin
            colour_class = CLASS_OTHER;
        end
    end

endmodule

[rtl/pick_and_place_colour_sequencer.sv]
// A request is held in the input register, and its response is registered
// in the result register. Throughput: one request per cycle while out_ready
// is high; the input and result registers hold one request each, and the
// phase register updates as a request moves across. Reset: rst_n clears both
// stages to empty, the phase to wait and min_level to 1000.
// ---------------------------------------------------------------------------
// Pick and place colour sequencer
// Seven-phase grab, lift, release and reset sequence driven by a colour
// classification of each sample and the actuator status flags.
// ---------------------------------------------------------------------------
module pick_and_place_colour_sequencer
    import pnp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CHAN_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  pnp_req_t            in_req,
    output logic                out_valid,
    input  logic                out_ready,
    output pnp_rsp_t            out_rsp
);

    typedef enum logic [2:0] {
        ST_WAIT      = 3'd0,
        ST_LOOKING   = 3'd1,
        ST_GRABBING  = 3'd2,
        ST_GRABBED   = 3'd3,
        ST_LIFTING   = 3'd4,
        ST_RELEASING = 3'd5,
        ST_RESETTING = 3'd6
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    state_t            state_cur;
    logic [CHAN_W-1:0] min_level_reg;
    logic              in_valid_reg;
    pnp_req_t          in_req_reg;
    logic              out_valid_reg;
    pnp_rsp_t          out_rsp_reg;
    pnp_rsp_t          rsp_next;
    logic [2:0]        colour_class;
    logic              advance;
    logic              is_red_or_green;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // colour of the held sample
    pnp_classify u_classify (
        .min_level    (min_level_reg),
        .red          (in_req_reg.red),
        .green        (in_req_reg.green),
        .blue         (in_req_reg.blue),
        .colour_class (colour_class)
    );

    assign is_red_or_green = (colour_class == CLASS_RED) || (colour_class == CLASS_GREEN);

    // next phase and commands for the held request
    always_comb
    begin
        state_cur              = state_reg;
        rsp_next               = '0;
        rsp_next.colour_class  = colour_class;

        // stop while active forces reset actions
        if (!in_req_reg.run_request && state_reg != ST_WAIT && state_reg != ST_RESETTING)
        begin
            rsp_next.lifter_action = LIFT_DOWN;
            rsp_next.pivot_target  = PIVOT_CENTRE;
            rsp_next.jaws_action   = JAWS_OPEN;
            state_cur              = ST_RESETTING;
        end

        state_next = state_cur;
        case (state_cur)
            ST_WAIT:
            begin
                if (in_req_reg.run_request)
                begin
                    state_next = ST_LOOKING;
                end
            end
            ST_LOOKING:
            begin
                if (is_red_or_green)
                begin
                    rsp_next.jaws_action = JAWS_CLOSE;
                    state_next           = ST_GRABBING;
                end
            end
            ST_GRABBING:
            begin
                if (in_req_reg.jaws_closed)
                begin
                    state_next = ST_GRABBED;
                end
                else
                begin
                    rsp_next.jaws_step = 1'b1;
                end
            end
            ST_GRABBED:
            begin
                if (is_red_or_green)
                begin
                    rsp_next.lifter_action = LIFT_UP;
                    rsp_next.pivot_target  = (colour_class == CLASS_RED) ?
                                             PIVOT_RED_SIDE : PIVOT_GREEN_SIDE;
                    state_next             = ST_LIFTING;
                end
            end
            ST_LIFTING:
            begin
                if (in_req_reg.lifter_up && in_req_reg.pivot_stopped)
                begin
                    rsp_next.jaws_action = JAWS_OPEN;
                    state_next           = ST_RELEASING;
                end
                else
                begin
                    rsp_next.lifter_step = 1'b1;
                    rsp_next.pivot_step  = 1'b1;
                end
            end
            ST_RELEASING:
            begin
                if (in_req_reg.jaws_open)
                begin
                    rsp_next.lifter_action = LIFT_DOWN;
                    rsp_next.pivot_target  = PIVOT_CENTRE;
                    state_next             = ST_RESETTING;
                end
                else
                begin
                    rsp_next.jaws_step = 1'b1;
                end
            end
            ST_RESETTING:
            begin
                if (in_req_reg.lifter_down && in_req_reg.pivot_stopped)
                begin
                    state_next = in_req_reg.run_request ? ST_LOOKING : ST_WAIT;
                end
                else
                begin
                    rsp_next.lifter_step = 1'b1;
                    rsp_next.pivot_step  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase

        rsp_next.phase = state_next;
    end

    // state, stages and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            min_level_reg <= MIN_LEVEL_RESET;
            in_valid_reg  <= 1'b0;
            in_req_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_rsp_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_level_reg <= cfg_wdata;
            end

            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
                in_req_reg   <= in_req;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_rsp_reg   <= rsp_next;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/pnp_checker.sv]
// ---------------------------------------------------------------------------
// Pick and place colour sequencer port checker
// Watches the top level's ports and checks handshake and response rules.
// ---------------------------------------------------------------------------
`include "pick_and_place_colour_sequencer_defines.svh"

module pnp_checker
    import pnp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input pnp_rsp_t out_rsp
);

    // a stalled response holds
    `PNP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rsp), "stalled response changed")

    // lifter and pivot always step together
    `PNP_ASSERT(a_steps_paired, clk, rst_n, !out_valid || (out_rsp.lifter_step == out_rsp.pivot_step), "lifter and pivot steps differ")

    // jaws only step while grabbing or releasing
    `PNP_ASSERT(a_jaws_step_phase, clk, rst_n, !(out_valid && out_rsp.jaws_step) || (out_rsp.phase == PHASE_GRABBING) || (out_rsp.phase == PHASE_RELEASING), "jaws step outside grab or release")

    // lifting either starts with a lift to a side or keeps stepping
    `PNP_ASSERT(a_lifting_cmd, clk, rst_n, !(out_valid && out_rsp.phase == PHASE_LIFTING) || out_rsp.lifter_step || ((out_rsp.lifter_action == LIFT_UP) && ((out_rsp.pivot_target == PIVOT_RED_SIDE) || (out_rsp.pivot_target == PIVOT_GREEN_SIDE))), "lifting without lift command or step")

endmodule

bind pick_and_place_colour_sequencer pnp_checker u_pnp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
);

[dv/pick_and_place_colour_sequencer_tb.sv]
// ---------------------------------------------------------------------------
// Pick and place colour sequencer testbench
// Drives sensor and status requests through the valid/ready port and checks
// every response against a request-level model of the phase sequence and the colour
// classifier. A directed walk through all phases is followed by random
// phases at several min_level settings, with bursts of idling on both sides but for the last.
// ---------------------------------------------------------------------------
module pick_and_place_colour_sequencer_tb
    import pnp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PER_SETTING = 210;
    localparam int NUM_SETTINGS = 6;
    localparam int DOM_OTHER_MAX = 43689;   // largest count a dominant colour can beat

    // status flag masks for directed requests: {closed, open, up, down, stopped}
    localparam bit [4:0] F_JC = 5'b10000;
    localparam bit [4:0] F_JO = 5'b01000;
    localparam bit [4:0] F_LU = 5'b00100;
    localparam bit [4:0] F_LD = 5'b00010;
    localparam bit [4:0] F_PS = 5'b00001;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CHAN_W-1:0] cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    pnp_req_t          in_req = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    pnp_rsp_t          out_rsp;

    pnp_req_t          tick_req_q[$];
    pnp_rsp_t          tick_rsp_q[$];

    logic [2:0]        phase_model = PHASE_WAIT;
    logic [CHAN_W-1:0] min_level_model = MIN_LEVEL_RESET;

    bit                idle_on = 1'b0;
    bit                in_taken = 1'b0;
    int                in_gap = 0;
    int                out_gap = 0;
    int                cycle_cnt = 0;
    int                req_cnt = 0;
    int                rsp_cnt = 0;
    int                mismatches = 0;
    int                errors = 0;
    int                picks_done = 0;

    pick_and_place_colour_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // x beats both others by more than a factor of 1.5
    function automatic bit beats(input int x, input int y, input int z);
        return (2 * x > 3 * y) && (2 * x > 3 * z);
    endfunction

    function automatic logic [2:0] colour_of(input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b);
        if (r < min_level_model || g < min_level_model || b < min_level_model)
            return CLASS_UNKNOWN;
        if (beats(r, g, b))
            return CLASS_RED;
        if (beats(g, r, b))
            return CLASS_GREEN;
        if (beats(b, r, g))
            return CLASS_BLUE;
        return CLASS_OTHER;
    endfunction

    // one control tick: expected response, advances the phase model
    function automatic pnp_rsp_t sequencer_tick(input pnp_req_t t);
        pnp_rsp_t   r;
        logic [2:0] ph;
        bit         pick;
        r = '0;
        r.colour_class = colour_of(t.red, t.green, t.blue);
        pick = (r.colour_class == CLASS_RED) || (r.colour_class == CLASS_GREEN);
        ph = phase_model;
        // stop while active forces reset actions, then the resetting check
        if (!t.run_request && ph != PHASE_WAIT && ph != PHASE_RESETTING)
        begin
            r.lifter_action = LIFT_DOWN;
            r.pivot_target  = PIVOT_CENTRE;
            r.jaws_action   = JAWS_OPEN;
            ph = PHASE_RESETTING;
        end
        case (ph)
            PHASE_WAIT:
            begin
                if (t.run_request)
                    ph = PHASE_LOOKING;
            end
            PHASE_LOOKING:
            begin
                if (pick)
                begin
                    r.jaws_action = JAWS_CLOSE;
                    ph = PHASE_GRABBING;
                end
            end
            PHASE_GRABBING:
            begin
                if (t.jaws_closed)
                    ph = PHASE_GRABBED;
                else
                    r.jaws_step = 1'b1;
            end
            PHASE_GRABBED:
            begin
                if (pick)
                begin
                    r.lifter_action = LIFT_UP;
                    r.pivot_target  = (r.colour_class == CLASS_RED) ? PIVOT_RED_SIDE
                                                                    : PIVOT_GREEN_SIDE;
                    ph = PHASE_LIFTING;
                end
            end
            PHASE_LIFTING:
            begin
                if (t.lifter_up && t.pivot_stopped)
                begin
                    r.jaws_action = JAWS_OPEN;
                    ph = PHASE_RELEASING;
                end
                else
                begin
                    r.lifter_step = 1'b1;
                    r.pivot_step  = 1'b1;
                end
            end
            PHASE_RELEASING:
            begin
                if (t.jaws_open)
                begin
                    r.lifter_action = LIFT_DOWN;
                    r.pivot_target  = PIVOT_CENTRE;
                    ph = PHASE_RESETTING;
                    picks_done++;
                end
                else
                begin
                    r.jaws_step = 1'b1;
                end
            end
            PHASE_RESETTING:
            begin
                if (t.lifter_down && t.pivot_stopped)
                begin
                    ph = t.run_request ? PHASE_LOOKING : PHASE_WAIT;
                end
                else
                begin
                    r.lifter_step = 1'b1;
                    r.pivot_step  = 1'b1;
                end
            end
            default:
            begin
                ph = PHASE_WAIT;
            end
        endcase
        phase_model = ph;
        r.phase = ph;
        return r;
    endfunction

    function automatic pnp_req_t mk_tick(input bit run, input int r, input int g,
                                         input int b, input bit [4:0] flags);
        pnp_req_t t;
        t.run_request   = run;
        t.red           = r[CHAN_W-1:0];
        t.green         = g[CHAN_W-1:0];
        t.blue          = b[CHAN_W-1:0];
        t.jaws_closed   = flags[4];
        t.jaws_open     = flags[3];
        t.lifter_up     = flags[2];
        t.lifter_down   = flags[1];
        t.pivot_stopped = flags[0];
        return t;
    endfunction

    // mostly well-formed requests with a chosen colour, some pure noise
    function automatic pnp_req_t random_tick();
        pnp_req_t t;
        int       ml;
        int       kind;
        int       x;
        int       y;
        int       z;
        int       m;
        ml = min_level_model;
        kind = $urandom_range(0, 19);
        t.run_request   = ($urandom_range(0, 19) != 0);
        t.jaws_closed   = $urandom_range(0, 1);
        t.jaws_open     = $urandom_range(0, 1);
        t.lifter_up     = $urandom_range(0, 1);
        t.lifter_down   = $urandom_range(0, 1);
        t.pivot_stopped = $urandom_range(0, 1);
        if (kind < 3)
        begin
            // noise
            t.run_request = $urandom_range(0, 1);
            t.red   = $urandom_range(0, 65535);
            t.green = $urandom_range(0, 65535);
            t.blue  = $urandom_range(0, 65535);
        end
        else if (kind < 16 && ml <= DOM_OTHER_MAX)
        begin
            // one dominant channel: red, green or now and then blue
            y = $urandom_range(ml, DOM_OTHER_MAX);
            z = $urandom_range(ml, DOM_OTHER_MAX);
            m = (y > z) ? y : z;
            x = $urandom_range((3 * m) / 2 + 1, 65535);
            if (kind < 9)
                t = mk_tick(t.run_request, x, y, z, {t.jaws_closed, t.jaws_open,
                            t.lifter_up, t.lifter_down, t.pivot_stopped});
            else if (kind < 15)
                t = mk_tick(t.run_request, y, x, z, {t.jaws_closed, t.jaws_open,
                            t.lifter_up, t.lifter_down, t.pivot_stopped});
            else
                t = mk_tick(t.run_request, y, z, x, {t.jaws_closed, t.jaws_open,
                            t.lifter_up, t.lifter_down, t.pivot_stopped});
        end
        else
        begin
            // all channels at or above the level, then maybe one below it
            t.red   = $urandom_range(ml, 65535);
            t.green = $urandom_range(ml, 65535);
            t.blue  = $urandom_range(ml, 65535);
            if (kind >= 18 && ml > 0)
            begin
                case ($urandom_range(0, 2))
                    0: t.red   = $urandom_range(0, ml - 1);
                    1: t.green = $urandom_range(0, ml - 1);
                    default: t.blue = $urandom_range(0, ml - 1);
                endcase
            end
        end
        return t;
    endfunction

    // wait until every request has gone through and been answered
    task automatic wait_all_done();
        while (tick_req_q.size() != 0 || in_valid || tick_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (tick_req_q.size() != 0)
            begin
                in_req   <= tick_req_q.pop_front();
                in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0)
                    in_gap = $urandom_range(1, 15);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (out_gap != 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0)
                out_gap = $urandom_range(1, 15);
        end
    end

    // prediction on accepted requests, checking of accepted responses
    always @(posedge clk)
    begin
        pnp_rsp_t want;
        if (rst_n)
        begin
            cycle_cnt++;
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                tick_rsp_q.push_back(sequencer_tick(in_req));
                req_cnt++;
            end
            if (out_valid && out_ready)
            begin
                rsp_cnt++;
                if (tick_rsp_q.size() == 0)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %0d: %p", rsp_cnt, out_rsp);
                end
                else
                begin
                    want = tick_rsp_q.pop_front();
                    if (out_rsp.phase !== want.phase
                        || out_rsp.jaws_action !== want.jaws_action
                        || out_rsp.lifter_action !== want.lifter_action
                        || out_rsp.pivot_target !== want.pivot_target
                        || out_rsp.jaws_step !== want.jaws_step
                        || out_rsp.lifter_step !== want.lifter_step
                        || out_rsp.pivot_step !== want.pivot_step
                        || out_rsp.colour_class !== want.colour_class)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d mismatch: expected %p, got %p",
                                     rsp_cnt, want, out_rsp);
                    end
                end
            end
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d responses pending",
                         cycle_cnt, tick_rsp_q.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // reset, directed walk, then random phases at several min_level settings
    initial
    begin
        logic [CHAN_W-1:0] level_set [NUM_SETTINGS];
        level_set[0] = 16'd0;
        level_set[1] = 16'hFFFF;
        level_set[2] = 16'd1000;
        level_set[3] = $urandom_range(2, 43000);
        level_set[4] = 16'd1;
        level_set[5] = 16'd1000;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk at the reset level of 1000
        idle_on = 1'b1;
        tick_req_q.push_back(mk_tick(0, 0, 0, 0, 5'b0));                  // idle in wait
        tick_req_q.push_back(mk_tick(1, 65535, 65535, 65535, 5'b0));      // start, ties
        tick_req_q.push_back(mk_tick(1, 1500, 1000, 1000, 5'b0));         // exactly 1.5x
        tick_req_q.push_back(mk_tick(1, 1000, 1000, 3000, 5'b0));         // blue ignored
        tick_req_q.push_back(mk_tick(1, 999, 5000, 5000, 5'b11111));      // below level
        tick_req_q.push_back(mk_tick(1, 1501, 1000, 1000, 5'b0));         // red, grab
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_JO | F_LU | F_LD | F_PS));
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_JC));                  // grabbed
        tick_req_q.push_back(mk_tick(1, 1000, 1000, 3000, 5'b11111));     // hold on blue
        tick_req_q.push_back(mk_tick(1, 65535, 0, 65535, 5'b0));          // hold on unknown
        tick_req_q.push_back(mk_tick(1, 65535, 1000, 1000, 5'b0));        // lift to red side
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_LU | F_JC | F_JO));
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_LU | F_PS));           // release
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_JC | F_LD | F_PS));
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_JO));                  // to resetting
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_LD | F_LU));
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_LD | F_PS));           // back to looking
        tick_req_q.push_back(mk_tick(1, 1000, 60000, 1000, 5'b0));        // green, grab
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, F_JC));
        tick_req_q.push_back(mk_tick(1, 1000, 60000, 1000, 5'b0));        // lift to green side
        tick_req_q.push_back(mk_tick(0, 0, 0, 0, F_LD | F_PS));           // stop, done at once
        tick_req_q.push_back(mk_tick(0, 0, 0, 0, 5'b11111));              // stop in wait
        tick_req_q.push_back(mk_tick(1, 0, 0, 0, 5'b0));
        tick_req_q.push_back(mk_tick(0, 0, 0, 0, 5'b0));                  // stop in looking
        tick_req_q.push_back(mk_tick(0, 65535, 65535, 65535, F_LD | F_PS));
        wait_all_done();

        // random phases, the last one with no idling
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            @(negedge clk);
            cfg_wdata <= level_set[p];
            cfg_we    <= 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
            min_level_model = level_set[p];
            idle_on = (p < NUM_SETTINGS - 1);
            for (int i = 0; i < RAND_PER_SETTING; i++)
                tick_req_q.push_back(random_tick());
            wait_all_done();
        end

        errors += tick_rsp_q.size();
        $display("%0d requests and %0d responses over %0d min_level settings (0 to 65535)",
                 req_cnt, rsp_cnt, NUM_SETTINGS + 1);
        $display("%0d complete pick cycles, %0d mismatches", picks_done, mismatches);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[pick_and_place_colour_sequencer.f]
+incdir+rtl
rtl/pnp_pkg.sv
rtl/pnp_classify.sv
rtl/pick_and_place_colour_sequencer.sv
rtl/pnp_checker.sv
dv/pick_and_place_colour_sequencer_tb.sv
